[hw/rtl/arpc_pkg.sv]
// Shared types and constants of the ARP address cache.
// Holds the request/result payload structs, operation and register codes,
// and the controller-to-datapath command struct. No dependencies.
package arpc_pkg;

  localparam int ARPC_ENTRIES = 8;
  localparam int IP_W         = 32;
  localparam int MAC_W        = 48;
  localparam int SLOT_W       = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_ADDRESS = 2'd2;

  typedef struct packed {
    logic             func;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_in;
  } arpc_req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [MAC_W-1:0]  mac_out;
    logic [IP_W-1:0]   looked_up_addr;
  } arpc_result_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic capture;      // latch request and match vectors
    logic commit;       // write insert into the table, emit insert result
    logic read_mac;     // read stored MAC of the lookup hit
    logic emit_lookup;  // load lookup result
  } arpc_cmd_t;

endpackage

[hw/rtl/arp_address_cache.sv]
// Top level of the ARP address cache: IPv4-to-MAC table with gateway
// substitution. Depends on arpc_pkg, arpc_ctrl and arpc_dpath.
//
// A request is taken when start is high and busy is low. The address is
// compared against every valid entry in the accept cycle; the next cycle
// runs the priority select and, for an insert, the table write. A lookup
// then adds a state for the registered read of the MAC memory. Each result
// appears on out_result for
// exactly one cycle with out_valid high and must be taken then: the
// receiver cannot stall the block. A new request may be accepted in the
// cycle the previous result is shown. Valid bits clear at reset, so no
// clearing pass is needed. Configuration writes are taken at any time but
// are meant to happen only while the block is idle.
module arp_address_cache #(
  parameter int ENTRIES = arpc_pkg::ARPC_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            start,
  input  arpc_pkg::arpc_req_t             in_req,
  output logic                            busy,
  output logic                            out_valid,
  output arpc_pkg::arpc_result_t          out_result
);
  import arpc_pkg::*;

  arpc_cmd_t cmd;
  logic      req_func;

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_func  (req_func),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  arpc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_req     (in_req),
    .cmd        (cmd),
    .req_func   (req_func),
    .out_result (out_result)
  );

endmodule

[hw/rtl/arpc_ctrl.sv]
// Controller of the ARP address cache: one-hot sequencer for one request.
// Depends on arpc_pkg; drives arpc_dpath through an arpc_cmd_t.
module arpc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               req_func,
  output arpc_pkg::arpc_cmd_t cmd,
  output logic               busy,
  output logic               out_valid
);
  import arpc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEL  = 3'b010,
    ST_RD   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SEL;
        end
      end
      ST_SEL: begin
        if (req_func == FUNC_INSERT) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.read_mac = 1'b1;
          state_nxt    = ST_RD;
        end
      end
      ST_RD: begin
        cmd.emit_lookup = 1'b1;
        out_valid_nxt   = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hw/rtl/arpc_dpath.sv]
// Datapath of the ARP address cache: config registers, address table,
// parallel compare, priority select and the MAC memory.
// Depends on arpc_pkg; sequenced by arpc_ctrl.
module arpc_dpath #(
  parameter int ENTRIES = arpc_pkg::ARPC_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  arpc_pkg::arpc_req_t                 in_req,
  input  arpc_pkg::arpc_cmd_t                 cmd,
  output logic                                req_func,
  output arpc_pkg::arpc_result_t              out_result
);
  import arpc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [IP_W-1:0]  own_r, mask_r, gw_r;
  logic [ENTRIES-1:0] valid_r;
  logic [IP_W-1:0]  addr_q_r [ENTRIES];
  logic [MAC_W-1:0] hw_mem   [ENTRIES];

  logic             func_r;
  logic [IP_W-1:0]  key_r;
  logic [MAC_W-1:0] mac_r;
  logic [ENTRIES-1:0] match_r, free_r;

  logic             hit_r;
  logic [IDX_W-1:0] slot_r;
  logic [MAC_W-1:0] rd_data_r;
  arpc_result_t     out_r, out_nxt;

  logic [IP_W-1:0]    key;
  logic [ENTRIES-1:0] match;
  logic               any_hit, any_free;
  logic [IDX_W-1:0]   hit_idx, free_idx, ins_idx;

  // Config registers; writes beyond the list drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r  <= '0;
      mask_r <= '0;
      gw_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OWN_ADDRESS:     own_r  <= cfg_wdata;
        REG_SUBNET_MASK:     mask_r <= cfg_wdata;
        REG_GATEWAY_ADDRESS: gw_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Off-subnet lookups search the gateway instead
  always_comb begin
    key = in_req.ip_addr;
    if (in_req.func == FUNC_LOOKUP &&
        ((in_req.ip_addr & mask_r) != (own_r & mask_r))) begin
      key = gw_r;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (addr_q_r[i] == key);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_req.func;
      key_r   <= key;
      mac_r   <= in_req.mac_in;
      match_r <= match;
      free_r  <= ~valid_r;
    end
  end

  // Lowest set bit wins: scan from the top so the last assignment holds
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    any_hit  = 1'b0;
    any_free = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_idx = IDX_W'(i);
        any_hit = 1'b1;
      end
      if (free_r[i]) begin
        free_idx = IDX_W'(i);
        any_free = 1'b1;
      end
    end
    if (any_hit) begin
      ins_idx = hit_idx;
    end else if (any_free) begin
      ins_idx = free_idx;
    end else begin
      ins_idx = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && !any_hit) begin
      valid_r[ins_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !any_hit) begin
      addr_q_r[ins_idx] <= key_r;
    end
  end

  // MAC memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hw_mem[ins_idx] <= mac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_mac) begin
      rd_data_r <= hw_mem[hit_idx];
      hit_r     <= any_hit;
      slot_r    <= hit_idx;
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.commit) begin
      out_nxt.hit            = any_hit;
      out_nxt.slot           = SLOT_W'(ins_idx);
      out_nxt.mac_out        = '0;
      out_nxt.looked_up_addr = key_r;
    end else if (cmd.emit_lookup) begin
      out_nxt.hit            = hit_r;
      out_nxt.slot           = SLOT_W'(slot_r);
      out_nxt.mac_out        = hit_r ? rd_data_r : '0;
      out_nxt.looked_up_addr = key_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign req_func   = func_r;
  assign out_result = out_r;

endmodule

[tb/testbench.sv]
// Self-checking testbench for arp_address_cache: a directed table, then phased random traffic.
// A built-in model of the table predicts every result that the plan does not give by hand.
// Depends on arpc_pkg and the arp_address_cache RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import arpc_pkg::*;

  localparam int ENTRIES         = ARPC_ENTRIES;
  localparam int RESET_CYCLES    = 8;
  localparam int DRAIN_CYCLES    = 6;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 182;
  localparam int POOL_SIZE       = 12;

  // index past the last register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    data;
    arpc_req_t                req;
    bit                       typed;
    arpc_result_t             want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  start = 1'b0;
  arpc_req_t             in_req = '0;
  logic                  busy;
  logic                  out_valid;
  arpc_result_t          out_result;

  // typed expectation travelling with the request being offered
  bit                    in_typed = 1'b0;
  arpc_result_t          in_want = '0;

  // model of the cache
  bit                    tbl_valid [ENTRIES];
  logic [IP_W-1:0]       tbl_ip [ENTRIES];
  logic [MAC_W-1:0]      tbl_mac [ENTRIES];
  logic [IP_W-1:0]       own_ip = '0;
  logic [IP_W-1:0]       net_mask = '0;
  logic [IP_W-1:0]       gw_ip = '0;

  arpc_result_t          expected_results [$];
  int                    errors = 0;
  int                    idle_cycles = 0;
  int                    burst_left = 0;

  arp_address_cache DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .in_req     (in_req),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic arpc_result_t cache_respond(input arpc_req_t r);
    arpc_result_t    res;
    logic [IP_W-1:0] key;
    int              found;
    res = '0;
    key = r.ip_addr;
    // off-subnet lookups go to the gateway
    if (r.func == FUNC_LOOKUP && ((key & net_mask) != (own_ip & net_mask))) key = gw_ip;
    found = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_ip[i] == key) found = i;
    end
    res.looked_up_addr = key;
    if (r.func == FUNC_LOOKUP) begin
      if (found >= 0) begin
        res.hit = 1'b1;
        res.slot = found[SLOT_W-1:0];
        res.mac_out = tbl_mac[found];
      end
    end else begin
      if (found >= 0) begin
        res.hit = 1'b1;
        tbl_mac[found] = r.mac_in;
      end else begin
        // first free slot, slot 0 when the table is full
        found = 0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) found = i;
        end
        tbl_valid[found] = 1'b1;
        tbl_ip[found] = key;
        tbl_mac[found] = r.mac_in;
      end
      res.slot = found[SLOT_W-1:0];
    end
    return res;
  endfunction

  task automatic check_result(input arpc_result_t got);
    arpc_result_t exp;
    if (expected_results.size() == 0) begin
      $error("unexpected result: hit %0b slot %0d mac_out %h looked_up_addr %h",
             got.hit, got.slot, got.mac_out, got.looked_up_addr);
      errors++;
      return;
    end
    exp = expected_results.pop_front();
    if (got.hit !== exp.hit) begin
      $error("hit: expected %0b, actual %0b", exp.hit, got.hit);
      errors++;
    end
    if (got.slot !== exp.slot) begin
      $error("slot: expected %0d, actual %0d", exp.slot, got.slot);
      errors++;
    end
    if (got.mac_out !== exp.mac_out) begin
      $error("mac_out: expected %h, actual %h", exp.mac_out, got.mac_out);
      errors++;
    end
    if (got.looked_up_addr !== exp.looked_up_addr) begin
      $error("looked_up_addr: expected %h, actual %h", exp.looked_up_addr, got.looked_up_addr);
      errors++;
    end
  endtask

  // Sample at the edge: config writes, results, then newly accepted requests.
  always @(posedge clk) begin
    arpc_result_t predicted;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_OWN_ADDRESS:     own_ip = cfg_wdata;
          REG_SUBNET_MASK:     net_mask = cfg_wdata;
          REG_GATEWAY_ADDRESS: gw_ip = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid) check_result(out_result);
      if (start && !busy) begin
        predicted = cache_respond(in_req);
        expected_results.push_back(in_typed ? in_want : predicted);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic plan_row_t req_row(input logic func, input logic [IP_W-1:0] ip,
                                        input logic [MAC_W-1:0] mac);
    plan_row_t row;
    row.kind = ROW_REQ;
    row.idx = '0;
    row.data = '0;
    row.req.func = func;
    row.req.ip_addr = ip;
    row.req.mac_in = mac;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic func, input logic [IP_W-1:0] ip,
                                          input logic [MAC_W-1:0] mac, input logic hit,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [MAC_W-1:0] mac_out,
                                          input logic [IP_W-1:0] addr);
    plan_row_t row;
    row = req_row(func, ip, mac);
    row.typed = 1'b1;
    row.want.hit = hit;
    row.want.slot = slot;
    row.want.mac_out = mac_out;
    row.want.looked_up_addr = addr;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = req_row(FUNC_LOOKUP, '0, '0);
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request, with a random gap at the start of each burst.
  task automatic issue(input arpc_req_t req, input bit typed, input arpc_result_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_req <= req;
    in_typed <= typed;
    in_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and let every outstanding result come back.
  task automatic wait_for_drain();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    plan_row_t             plan [$];
    logic [IP_W-1:0]       pool [POOL_SIZE];
    logic [CFG_DATA_W-1:0] regs [3];
    logic [63:0]           wide;
    arpc_req_t             req;
    int                    net_len;
    int                    rot;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, zero registers: every address is on the subnet
    plan.push_back(typed_row(FUNC_LOOKUP, 32'h0, 48'h0, 1'b0, 3'd0, 48'h0, 32'h0));
    plan.push_back(typed_row(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                             1'b0, 3'd0, 48'h0, 32'hFFFF_FFFF));
    plan.push_back(typed_row(FUNC_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                             1'b0, 3'd0, 48'h0, 32'hFFFF_FFFF));
    plan.push_back(typed_row(FUNC_INSERT, 32'h0, 48'h0, 1'b0, 3'd1, 48'h0, 32'h0));
    plan.push_back(typed_row(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0,
                             1'b1, 3'd0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    // update in place reports a hit
    plan.push_back(typed_row(FUNC_INSERT, 32'hFFFF_FFFF, 48'h5A5A_0F0F_A5A5,
                             1'b1, 3'd0, 48'h0, 32'hFFFF_FFFF));
    plan.push_back(req_row(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0));
    for (int i = 2; i < ENTRIES; i++) begin
      plan.push_back(req_row(FUNC_INSERT, 32'h0A00_0000 + i, {16'h00A0, 32'h0 + i}));
    end
    // table full: slot 0 is overwritten
    plan.push_back(typed_row(FUNC_INSERT, 32'h0A00_0010, 48'h1234_5678_9ABC,
                             1'b0, 3'd0, 48'h0, 32'h0A00_0010));
    plan.push_back(typed_row(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0,
                             1'b0, 3'd0, 48'h0, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_OWN_ADDRESS, 32'h0A00_0001));
    plan.push_back(cfg_row(REG_SUBNET_MASK, 32'hFFFF_FF00));
    plan.push_back(cfg_row(REG_GATEWAY_ADDRESS, 32'h0A00_0005));
    plan.push_back(req_row(FUNC_LOOKUP, 32'h0A00_0003, 48'h0));
    plan.push_back(req_row(FUNC_LOOKUP, 32'hC0A8_0001, 48'h0));
    // insert takes the address as given, even off the subnet
    plan.push_back(typed_row(FUNC_INSERT, 32'hC0A8_0001, 48'h8000_0000_0001,
                             1'b0, 3'd0, 48'h0, 32'hC0A8_0001));
    plan.push_back(req_row(FUNC_LOOKUP, 32'hC0A8_0001, 48'h0));
    plan.push_back(cfg_row(REG_GATEWAY_ADDRESS, 32'hFFFF_FFFF));
    plan.push_back(typed_row(FUNC_LOOKUP, 32'h0102_0304, 48'h0,
                             1'b0, 3'd0, 48'h0, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_UNUSED, 32'h0A00_0001));
    plan.push_back(cfg_row(REG_SUBNET_MASK, 32'hFFFF_FFFF));
    plan.push_back(typed_row(FUNC_LOOKUP, 32'h0A00_0001, 48'h0,
                             1'b0, 3'd0, 48'h0, 32'h0A00_0001));
    plan.push_back(typed_row(FUNC_LOOKUP, 32'h0A00_0002, 48'h0,
                             1'b0, 3'd0, 48'h0, 32'hFFFF_FFFF));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_for_drain();
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        issue(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_for_drain();
      case (p)
        0: begin
          regs[REG_OWN_ADDRESS] = $urandom;
          regs[REG_SUBNET_MASK] = 32'h0;
        end
        1: begin
          regs[REG_OWN_ADDRESS] = 32'hFFFF_FFFF;
          regs[REG_SUBNET_MASK] = 32'hFFFF_FFFF;
        end
        2: begin
          regs[REG_OWN_ADDRESS] = 32'h0;
          regs[REG_SUBNET_MASK] = 32'hFFFF_FFFF;
        end
        default: begin
          regs[REG_OWN_ADDRESS] = $urandom;
          net_len = $urandom_range(0, 32);
          regs[REG_SUBNET_MASK] = (net_len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - net_len));
          if ($urandom_range(0, 3) == 0) regs[REG_SUBNET_MASK] = $urandom;
        end
      endcase
      // half the pool on the subnet, half anywhere
      for (int k = 0; k < POOL_SIZE; k++) begin
        if (k % 2 == 0) begin
          pool[k] = (regs[REG_OWN_ADDRESS] & regs[REG_SUBNET_MASK]) |
                    ($urandom & ~regs[REG_SUBNET_MASK]);
        end else begin
          pool[k] = $urandom;
        end
      end
      case (p)
        0: regs[REG_GATEWAY_ADDRESS] = pool[$urandom_range(0, POOL_SIZE - 1)];
        1: regs[REG_GATEWAY_ADDRESS] = 32'h0;
        2: regs[REG_GATEWAY_ADDRESS] = 32'hFFFF_FFFF;
        default: regs[REG_GATEWAY_ADDRESS] =
            ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
      endcase
      pool[1] = regs[REG_GATEWAY_ADDRESS];
      rot = $urandom_range(0, 2);
      for (int j = 0; j < 3; j++) begin
        cfg_write(CFG_IDX_W'((rot + j) % 3), regs[(rot + j) % 3]);
      end
      if (p >= 3 && $urandom_range(0, 1) == 1) cfg_write(REG_UNUSED, $urandom);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        req.func = ($urandom_range(0, 9) < 4) ? FUNC_INSERT : FUNC_LOOKUP;
        req.ip_addr = ($urandom_range(0, 99) < 8) ? $urandom
                                                   : pool[$urandom_range(0, POOL_SIZE - 1)];
        wide = {$urandom, $urandom};
        req.mac_in = wide[MAC_W-1:0];
        issue(req, 1'b0, '0);
      end
    end

    wait_for_drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
